// ===== rtl/dpid_pkg.sv =====
// ============================================================================
// dpid_pkg
// Shared types and constants for the dual axis pid servo controller:
// channel items, configuration register set, controller commands.
// ============================================================================
`default_nettype none

package dpid_pkg;

  // field widths
  localparam int unsigned POS_W   = 12;
  localparam int unsigned GAIN_W  = 20;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned ERR_W   = 13;
  localparam int unsigned DIFF_W  = 14;
  localparam int unsigned SUM_W   = 24;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDATA_W = 20;

  // multiplier and accumulator widths
  localparam int unsigned MUL_A_W = GAIN_W + 1;
  localparam int unsigned MUL_B_W = SUM_W + 1;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W   = PROD_W + 1;
  localparam int unsigned ACC3_W  = ACC_W + 2;
  localparam int unsigned RND_SH  = 13;
  localparam int unsigned SCL_W   = ACC3_W - RND_SH;
  localparam int unsigned DSUM_W  = SCL_W + 1;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_KP_GAIN     = 3'd0;
  localparam logic [CIDX_W-1:0] REG_KI_GAIN     = 3'd1;
  localparam logic [CIDX_W-1:0] REG_KD_GAIN     = 3'd2;
  localparam logic [CIDX_W-1:0] REG_DUTY_CENTER = 3'd3;
  localparam logic [CIDX_W-1:0] REG_DUTY_MIN    = 3'd4;
  localparam logic [CIDX_W-1:0] REG_DUTY_MAX    = 3'd5;

  // configuration reset values
  localparam logic [GAIN_W-1:0] KP_RST     = 20'd2048;
  localparam logic [GAIN_W-1:0] KI_RST     = 20'd0;
  localparam logic [GAIN_W-1:0] KD_RST     = 20'd32768;
  localparam logic [DUTY_W-1:0] CENTER_RST = 16'd1500;
  localparam logic [DUTY_W-1:0] MIN_RST    = 16'd900;
  localparam logic [DUTY_W-1:0] MAX_RST    = 16'd2100;

  // running sum limits
  localparam logic signed [MUL_B_W-1:0] SUM_MAX = 25'sd8388607;
  localparam logic signed [MUL_B_W-1:0] SUM_MIN = -25'sd8388608;

  // rounding offset for the 1.5 scale (3 / 8192 in Q12)
  localparam logic signed [ACC3_W-1:0] RND_OFS = 49'sd4096;

  typedef struct packed {
    logic              axis;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  setpoint;
  } in_item_t;

  typedef struct packed {
    logic              axis_out;
    logic [DUTY_W-1:0] duty_us;
    logic              clamped;
  } out_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp_gain;
    logic [GAIN_W-1:0] ki_gain;
    logic [GAIN_W-1:0] kd_gain;
    logic [DUTY_W-1:0] duty_center;
    logic [DUTY_W-1:0] duty_min;
    logic [DUTY_W-1:0] duty_max;
  } cfg_regs_t;

  typedef enum logic [1:0] {
    MUL_P = 2'd0,
    MUL_I = 2'd1,
    MUL_D = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     calc_err;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     acc_add;
    logic     scale;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_ERR  = 8'b0000_0010,
    ST_MP   = 8'b0000_0100,
    ST_MI   = 8'b0000_1000,
    ST_MD   = 8'b0001_0000,
    ST_ACC  = 8'b0010_0000,
    ST_SCL  = 8'b0100_0000,
    ST_CLP  = 8'b1000_0000
  } ctrl_state_t;

endpackage

`default_nettype wire

// ===== rtl/dpid_cfg_regs.sv =====
// ============================================================================
// dpid_cfg_regs
// Configuration register file: gains, duty center and duty limits,
// written through a plain write port, values masked to register width.
// ============================================================================
`default_nettype none

module dpid_cfg_regs
  import dpid_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CIDX_W-1:0]  cfg_index,
  input  wire logic [CDATA_W-1:0] cfg_wdata,
  output cfg_regs_t               regs
);

  cfg_regs_t regs_r, regs_nxt;

  // decode the write, unknown indexes are dropped
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_KP_GAIN:     regs_nxt.kp_gain     = cfg_wdata[GAIN_W-1:0];
        REG_KI_GAIN:     regs_nxt.ki_gain     = cfg_wdata[GAIN_W-1:0];
        REG_KD_GAIN:     regs_nxt.kd_gain     = cfg_wdata[GAIN_W-1:0];
        REG_DUTY_CENTER: regs_nxt.duty_center = cfg_wdata[DUTY_W-1:0];
        REG_DUTY_MIN:    regs_nxt.duty_min    = cfg_wdata[DUTY_W-1:0];
        REG_DUTY_MAX:    regs_nxt.duty_max    = cfg_wdata[DUTY_W-1:0];
        default:         regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.kp_gain     <= KP_RST;
      regs_r.ki_gain     <= KI_RST;
      regs_r.kd_gain     <= KD_RST;
      regs_r.duty_center <= CENTER_RST;
      regs_r.duty_min    <= MIN_RST;
      regs_r.duty_max    <= MAX_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

`default_nettype wire

// ===== rtl/dpid_ctrl.sv =====
// ============================================================================
// dpid_ctrl
// Sequencer for one pid update: error step, three passes through the
// shared multiplier, accumulate, scale, then clamp into the output register.
// ============================================================================
`default_nettype none

module dpid_ctrl
  import dpid_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        in_take;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.mul_sel  = MUL_P;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd.calc_err = 1'b1;
        state_nxt    = ST_MP;
      end
      ST_MP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_P;
        state_nxt   = ST_MI;
      end
      ST_MI: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_I;
        cmd.acc_load = 1'b1;
        state_nxt    = ST_MD;
      end
      ST_MD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_D;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_add = 1'b1;
        state_nxt   = ST_SCL;
      end
      ST_SCL: begin
        cmd.scale = 1'b1;
        state_nxt = ST_CLP;
      end
      ST_CLP: begin
        // wait here while the previous result still sits in the output register
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dpid_datapath.sv =====
// ============================================================================
// dpid_datapath
// Per-axis error state, shared signed multiplier with accumulator,
// 1.5x rounding scale, duty clamp and the output register.
// ============================================================================
`default_nettype none

module dpid_datapath
  import dpid_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_data,
  input  wire cfg_regs_t regs,
  input  wire dp_cmd_t   cmd,
  output dp_status_t     status,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  // captured input
  in_item_t in_r;

  // per-axis state
  logic signed [SUM_W-1:0] sum_st_r  [2];
  logic signed [ERR_W-1:0] last_st_r [2];

  // per-item working registers
  logic signed [ERR_W-1:0]  err_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [SCL_W-1:0]  scl_r;
  logic                     out_valid_r;
  out_item_t                out_r;

  // error step signals
  logic signed [ERR_W-1:0]   err;
  logic signed [MUL_B_W-1:0] sum_raw;
  logic signed [SUM_W-1:0]   sum_sat;
  logic signed [DIFF_W-1:0]  diff;

  // multiplier operands
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   prod_ext;

  // scale and clamp
  logic signed [ACC3_W-1:0]  acc3;
  logic signed [DSUM_W-1:0]  duty;
  logic signed [DSUM_W-1:0]  dmin;
  logic signed [DSUM_W-1:0]  dmax;
  logic                      below;
  logic                      above;
  out_item_t                 out_nxt;

  // error, saturating sum and difference for the served axis
  always_comb begin
    err     = $signed({1'b0, in_r.setpoint}) - $signed({1'b0, in_r.position});
    sum_raw = MUL_B_W'(sum_st_r[in_r.axis]) + MUL_B_W'(err);
    if (sum_raw > SUM_MAX) begin
      sum_sat = SUM_W'(SUM_MAX);
    end else if (sum_raw < SUM_MIN) begin
      sum_sat = SUM_W'(SUM_MIN);
    end else begin
      sum_sat = sum_raw[SUM_W-1:0];
    end
    diff = DIFF_W'(err) - DIFF_W'(last_st_r[in_r.axis]);
  end

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      MUL_P: begin
        mul_a = $signed({1'b0, regs.kp_gain});
        mul_b = MUL_B_W'(err_r);
      end
      MUL_I: begin
        mul_a = $signed({1'b0, regs.ki_gain});
        mul_b = MUL_B_W'(sum_r);
      end
      MUL_D: begin
        mul_a = $signed({1'b0, regs.kd_gain});
        mul_b = MUL_B_W'(diff_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_ext = ACC_W'(prod_r);

  // 3*acc + 4096, floor divide by 8192 is the arithmetic shift
  assign acc3 = ACC3_W'(acc_r) + (ACC3_W'(acc_r) <<< 1) + RND_OFS;

  // center plus drive, clamp with the low limit checked first
  always_comb begin
    duty  = $signed({{(DSUM_W-DUTY_W){1'b0}}, regs.duty_center}) + DSUM_W'(scl_r);
    dmin  = $signed({{(DSUM_W-DUTY_W){1'b0}}, regs.duty_min});
    dmax  = $signed({{(DSUM_W-DUTY_W){1'b0}}, regs.duty_max});
    below = (duty < dmin);
    above = (duty > dmax);
    out_nxt.axis_out = in_r.axis;
    if (below) begin
      out_nxt.duty_us = regs.duty_min;
      out_nxt.clamped = 1'b1;
    end else if (above) begin
      out_nxt.duty_us = regs.duty_max;
      out_nxt.clamped = 1'b1;
    end else begin
      out_nxt.duty_us = duty[DUTY_W-1:0];
      out_nxt.clamped = 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.calc_err) begin
      err_r  <= err;
      sum_r  <= sum_sat;
      diff_r <= diff;
    end
    if (cmd.mul_en) begin
      prod_r <= prod;
    end
    if (cmd.acc_load) begin
      acc_r <= prod_ext;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + prod_ext;
    end
    if (cmd.scale) begin
      scl_r <= acc3[ACC3_W-1:RND_SH];
    end
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  // axis state, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_st_r[0]  <= '0;
      sum_st_r[1]  <= '0;
      last_st_r[0] <= '0;
      last_st_r[1] <= '0;
    end else if (cmd.calc_err) begin
      sum_st_r[in_r.axis]  <= sum_sat;
      last_st_r[in_r.axis] <= err;
    end
  end

  // output beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;

endmodule

`default_nettype wire

// ===== rtl/dual_axis_pid_servo.sv =====
// ============================================================================
// dual_axis_pid_servo
// Two-axis pid controller for a servo-tilted plate: per-axis error sum and
// last error, shared gain multiplier, 1.5x scale to microseconds, clamp.
// ============================================================================
//
//  channel  direction  payload       handshake
//  in_      input      in_item_t     in_valid / in_stall
//  out_     output     out_item_t    out_valid / out_stall
//  cfg_     input      index, wdata  cfg_we, no wait
//
//  a beat's result lands in the output register after the ERR, MP, MI, MD,
//  ACC, SCL and CLP states, and no new beat is taken before that: the
//  three gain products go one after another through a single multiplier.
//  a new beat is taken once the previous one reaches the output register,
//  even while that result is still stalled; a stalled result holds the
//  update in its last cycle. rst_n is synchronous and clears both axes'
//  error state and loads the default gains and duty limits.
// ============================================================================
`default_nettype none

module dual_axis_pid_servo
  import dpid_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_item_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_item_t               out_data,
  input  wire logic               cfg_we,
  input  wire logic [CIDX_W-1:0]  cfg_index,
  input  wire logic [CDATA_W-1:0] cfg_wdata
);

  cfg_regs_t  regs;
  dp_cmd_t    cmd;
  dp_status_t status;

  // configuration registers
  dpid_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  // sequencer
  dpid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and output register
  dpid_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .regs      (regs),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for dual_axis_pid_servo
// Drives position/setpoint beats for both axes while the result side stalls
// at random. A model of the controller predicts every duty beat,
// and a monitor compares each accepted result field by field. The run covers
// default gains, field extremes, the clamp rules (min above max included),
// the register map and randomized traffic under several gain and duty
// settings.
// ----------------------------------------------------------------------------

module tb;
  import dpid_pkg::*;

  localparam int unsigned CYCLE_LIMIT        = 600000;
  localparam int unsigned DRAIN_CYCLES       = 12;
  localparam int unsigned PHASES             = 3;
  localparam int unsigned SETTINGS_PER_PHASE = 5;
  localparam int unsigned BEATS_PER_SETTING  = 127;
  localparam int unsigned REPORT_LINES       = 30;

  // unmapped register indexes, writes there must be ignored
  localparam logic [CIDX_W-1:0] IDX_SPARE_6 = 3'd6;
  localparam logic [CIDX_W-1:0] IDX_SPARE_7 = 3'd7;

  localparam logic [GAIN_W-1:0] GAIN_FULL = '1;
  localparam logic [DUTY_W-1:0] DUTY_FULL = '1;
  localparam logic [POS_W-1:0]  POS_FULL  = '1;

  typedef enum int {
    CFG_LOW,
    CFG_HIGH,
    CFG_TYPICAL,
    CFG_WILD
  } cfg_kind_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [CDATA_W-1:0]  cfg_wdata = '0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned beats_sent = 0;
  int unsigned results_seen = 0;
  int unsigned clamp_hits = 0;
  int unsigned cfg_writes = 0;
  int unsigned mismatch_count = 0;

  // controller model state and register copy
  logic signed [SUM_W-1:0] axis_sum [2];
  logic signed [ERR_W-1:0] axis_prev_err [2];
  logic [GAIN_W-1:0]       kp_q, ki_q, kd_q;
  logic [DUTY_W-1:0]       center_us, min_us, max_us;

  out_item_t duty_expect_q [$];

  dual_axis_pid_servo uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // one pid update: error, saturating sum, difference, scaled drive, clamp
  function automatic out_item_t servo_predict(in_item_t beat);
    longint    err, sum, diff, drive, duty;
    out_item_t res;
    err = longint'(beat.setpoint) - longint'(beat.position);
    sum = longint'(axis_sum[beat.axis]) + err;
    if (sum > longint'(SUM_MAX)) sum = longint'(SUM_MAX);
    if (sum < longint'(SUM_MIN)) sum = longint'(SUM_MIN);
    axis_sum[beat.axis] = sum[SUM_W-1:0];
    diff = err - longint'(axis_prev_err[beat.axis]);
    axis_prev_err[beat.axis] = err[ERR_W-1:0];
    drive = longint'(kp_q) * err + longint'(ki_q) * sum + longint'(kd_q) * diff;
    // 1.5x in Q12, ties toward plus infinity
    drive = (drive * 3 + 4096) >>> 13;
    duty = longint'(center_us) + drive;
    res.axis_out = beat.axis;
    res.clamped  = 1'b0;
    if (duty < longint'(min_us)) begin
      duty = longint'(min_us);
      res.clamped = 1'b1;
    end else if (duty > longint'(max_us)) begin
      duty = longint'(max_us);
      res.clamped = 1'b1;
    end
    res.duty_us = duty[DUTY_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    mismatch_count++;
    if (mismatch_count <= REPORT_LINES)
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got_v, want_v);
  endtask

  // model update and result checking, all on the sampled edge values
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      kp_q = KP_RST;
      ki_q = KI_RST;
      kd_q = KD_RST;
      center_us = CENTER_RST;
      min_us = MIN_RST;
      max_us = MAX_RST;
      axis_sum[0] = '0;
      axis_sum[1] = '0;
      axis_prev_err[0] = '0;
      axis_prev_err[1] = '0;
    end else begin
      // result beat against the oldest expectation
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_data.clamped) clamp_hits++;
        if (duty_expect_q.size() == 0) begin
          report_mismatch("result with none expected, duty_us", 32'(out_data.duty_us), 0);
        end else begin
          want = duty_expect_q.pop_front();
          if (out_data.axis_out !== want.axis_out)
            report_mismatch("axis_out", 32'(out_data.axis_out), 32'(want.axis_out));
          if (out_data.duty_us !== want.duty_us)
            report_mismatch("duty_us", 32'(out_data.duty_us), 32'(want.duty_us));
          if (out_data.clamped !== want.clamped)
            report_mismatch("clamped", 32'(out_data.clamped), 32'(want.clamped));
        end
      end
      // register write
      if (cfg_we) begin
        case (cfg_index)
          REG_KP_GAIN:     kp_q = cfg_wdata[GAIN_W-1:0];
          REG_KI_GAIN:     ki_q = cfg_wdata[GAIN_W-1:0];
          REG_KD_GAIN:     kd_q = cfg_wdata[GAIN_W-1:0];
          REG_DUTY_CENTER: center_us = cfg_wdata[DUTY_W-1:0];
          REG_DUTY_MIN:    min_us = cfg_wdata[DUTY_W-1:0];
          REG_DUTY_MAX:    max_us = cfg_wdata[DUTY_W-1:0];
          default: ;
        endcase
      end
      // input beat
      if (in_valid && !in_stall)
        duty_expect_q.push_back(servo_predict(in_data));
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // one input beat, with an optional sender gap first; valid stays high after
  task automatic send_beat(input logic ax, input logic [POS_W-1:0] pos_v,
                           input logic [POS_W-1:0] set_v);
    in_item_t beat;
    int       gap;
    beat.axis     = ax;
    beat.position = pos_v;
    beat.setpoint = set_v;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  // hold the sender until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (duty_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_writes++;
  endtask

  task automatic load_settings(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                               input logic [GAIN_W-1:0] kd, input logic [DUTY_W-1:0] ctr,
                               input logic [DUTY_W-1:0] lo, input logic [DUTY_W-1:0] hi);
    wait_drained();
    write_reg(REG_KP_GAIN, kp);
    write_reg(REG_KI_GAIN, ki);
    write_reg(REG_KD_GAIN, kd);
    write_reg(REG_DUTY_CENTER, CDATA_W'(ctr));
    write_reg(REG_DUTY_MIN, CDATA_W'(lo));
    write_reg(REG_DUTY_MAX, CDATA_W'(hi));
    cfg_we <= 1'b0;
  endtask

  task automatic load_random_settings(input cfg_kind_t kind);
    logic [GAIN_W-1:0] kp, ki, kd;
    logic [DUTY_W-1:0] ctr, lo, hi, swap_v;
    case (kind)
      CFG_LOW: begin
        kp = '0; ki = '0; kd = '0;
        ctr = '0; lo = '0; hi = '0;
      end
      CFG_HIGH: begin
        kp = GAIN_FULL; ki = GAIN_FULL; kd = GAIN_FULL;
        ctr = DUTY_FULL; lo = DUTY_FULL; hi = DUTY_FULL;
      end
      CFG_TYPICAL: begin
        kp  = GAIN_W'($urandom_range(0, 8192));
        ki  = GAIN_W'($urandom_range(0, 64));
        kd  = GAIN_W'($urandom_range(0, 8192));
        ctr = DUTY_W'($urandom_range(1000, 2000));
        lo  = DUTY_W'($urandom_range(500, 1500));
        hi  = DUTY_W'($urandom_range(1500, 2500));
        // now and then an inverted window
        if ($urandom_range(0, 9) == 0) begin
          swap_v = lo;
          lo = hi;
          hi = swap_v;
        end
      end
      default: begin
        kp  = GAIN_W'($urandom);
        ki  = GAIN_W'($urandom);
        kd  = GAIN_W'($urandom);
        ctr = DUTY_W'($urandom);
        lo  = DUTY_W'($urandom);
        hi  = DUTY_W'($urandom);
      end
    endcase
    load_settings(kp, ki, kd, ctr, lo, hi);
  endtask

  function automatic logic [POS_W-1:0] edge_pos();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return POS_FULL;
      default: return POS_W'($urandom);
    endcase
  endfunction

  // mostly a ball near its target, some full-range jumps, some rail values
  task automatic send_random_beat();
    int              r, offs, p;
    logic            ax;
    logic [POS_W-1:0] pos_v, set_v;
    r     = $urandom_range(0, 99);
    ax    = 1'($urandom_range(0, 1));
    set_v = POS_W'($urandom_range(0, 4095));
    if (r < 60) begin
      offs = $urandom_range(0, 128);
      p = int'(set_v) + offs - 64;
      if (p < 0) p = 0;
      if (p > 4095) p = 4095;
      pos_v = p[POS_W-1:0];
    end else if (r < 85) begin
      pos_v = POS_W'($urandom_range(0, 4095));
    end else begin
      pos_v = edge_pos();
      set_v = edge_pos();
    end
    send_beat(ax, pos_v, set_v);
  endtask

  // reset gains: zero error, small errors, rounding tie toward plus infinity
  task automatic test_reset_defaults();
    send_beat(1'b0, 12'd2048, 12'd2048);
    send_beat(1'b1, 12'd2000, 12'd2010);
    send_beat(1'b0, 12'd2050, 12'd2048);
    send_beat(1'b1, 12'd2010, 12'd2010);
  endtask

  task automatic test_field_extremes();
    send_beat(1'b0, '0, POS_FULL);
    send_beat(1'b0, POS_FULL, '0);
    send_beat(1'b1, POS_FULL, '0);
    send_beat(1'b1, '0, POS_FULL);
    send_beat(1'b0, POS_FULL, POS_FULL);
    send_beat(1'b1, '0, '0);
  endtask

  // duty right at and just past the limits, inverted window, rail centers
  task automatic test_clamp_limits();
    load_settings(20'd4096, '0, '0, 16'd1500, 16'd1400, 16'd1600);
    send_beat(1'b0, 12'd2000, 12'd2066);
    send_beat(1'b0, 12'd2000, 12'd2067);
    send_beat(1'b0, 12'd2000, 12'd2068);
    send_beat(1'b1, 12'd2066, 12'd2000);
    send_beat(1'b1, 12'd2067, 12'd2000);
    send_beat(1'b1, 12'd2068, 12'd2000);
    // min above max
    load_settings(20'd4096, '0, '0, 16'd1500, 16'd1600, 16'd1400);
    send_beat(1'b0, 12'd1000, 12'd1000);
    send_beat(1'b1, 12'd1000, 12'd1100);
    load_settings(20'd4096, '0, '0, '0, '0, DUTY_FULL);
    send_beat(1'b0, 12'd1001, 12'd1000);
    load_settings(20'd4096, '0, '0, DUTY_FULL, '0, DUTY_FULL);
    send_beat(1'b1, 12'd1000, 12'd1001);
  endtask

  // unmapped indexes ignored, duty registers take only their low bits
  task automatic test_register_map();
    wait_drained();
    write_reg(IDX_SPARE_6, CDATA_W'($urandom));
    write_reg(IDX_SPARE_7, CDATA_W'($urandom));
    write_reg(REG_KP_GAIN, 20'd2048);
    write_reg(REG_DUTY_CENTER, {4'hF, 16'd1500});
    write_reg(REG_DUTY_MIN, {4'hA, 16'd900});
    write_reg(REG_DUTY_MAX, {4'h5, 16'd2100});
    cfg_we <= 1'b0;
    send_beat(1'b0, 12'd1500, 12'd1510);
    send_beat(1'b1, 12'd1510, 12'd1500);
    load_settings(GAIN_FULL, GAIN_FULL, GAIN_FULL, 16'd32768, '0, DUTY_FULL);
    send_beat(1'b0, 12'd3000, 12'd3001);
    send_beat(1'b1, 12'd3001, 12'd3000);
  endtask

  task automatic test_random_traffic();
    cfg_kind_t kind;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       set_idling(38, 77);
        1:       set_idling(77, 38);
        default: set_idling(0, 0);
      endcase
      for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
        if (s == 0 && ph == 0)
          kind = CFG_LOW;
        else if (s == 0 && ph == 1)
          kind = CFG_HIGH;
        else if ($urandom_range(0, 3) == 0)
          kind = CFG_WILD;
        else
          kind = CFG_TYPICAL;
        load_random_settings(kind);
        for (int i = 0; i < BEATS_PER_SETTING; i++) begin
          // sender holds off until the pipe is empty, settings unchanged
          if (ph == 0 && s == 2 && i == BEATS_PER_SETTING / 2)
            wait_drained();
          send_random_beat();
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idling(38, 77);
    test_reset_defaults();
    test_field_extremes();
    test_clamp_limits();
    test_register_map();
    test_random_traffic();
    wait_drained();
    $display("run covered %0d beats, %0d results checked (%0d clamped), %0d register writes",
             beats_sent, results_seen, clamp_hits, cfg_writes);
    $display("settings swept from all-zero to all-ones under three idling mixes");
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dpid_pkg.sv
rtl/dpid_cfg_regs.sv
rtl/dpid_ctrl.sv
rtl/dpid_datapath.sv
rtl/dual_axis_pid_servo.sv
verif/tb.sv
